[rtl/pia_pkg.sv]
package pia_pkg;

	localparam int FIELD_BITS     = 24;
	localparam int INDEX_BITS_DEF = 24;
	localparam int MODE_BITS      = 3;
	localparam int COUNT_BITS     = 2;
	localparam int HELD_DEPTH     = 3;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_TRIS   = 3'd0,
		MODE_STRIP  = 3'd1,
		MODE_FAN    = 3'd2,
		MODE_QUADS  = 3'd3,
		MODE_QSTRIP = 3'd4
	} mode_e;

	typedef struct packed {
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
		logic [FIELD_BITS-1:0] c;
		logic                  last;
	} face_t;

endpackage

[rtl/pia_assemble.sv]
module pia_assemble #(
	parameter int HELD_BITS = pia_pkg::FIELD_BITS
) (
	input  logic [pia_pkg::MODE_BITS-1:0]                            mode,
	input  logic                                                     group_start,
	input  logic [HELD_BITS-1:0]                                     vertex_id,
	input  logic [pia_pkg::COUNT_BITS-1:0]                           count,
	input  logic [pia_pkg::HELD_DEPTH-1:0][HELD_BITS-1:0]            held,
	output logic [pia_pkg::COUNT_BITS-1:0]                           count_next,
	output logic [pia_pkg::HELD_DEPTH-1:0][HELD_BITS-1:0]            held_next,
	output pia_pkg::face_t                                           face_first,
	output pia_pkg::face_t                                           face_second,
	output logic [1:0]                                               face_num
);
	import pia_pkg::*;

	function automatic face_t make_face(
		input logic [HELD_BITS-1:0] a,
		input logic [HELD_BITS-1:0] b,
		input logic [HELD_BITS-1:0] c,
		input logic                 last
	);
		face_t f;
		f.a    = FIELD_BITS'(a);
		f.b    = FIELD_BITS'(b);
		f.c    = FIELD_BITS'(c);
		f.last = last;
		return f;
	endfunction

	logic [COUNT_BITS-1:0] n;
	logic                  append;

	always_comb begin
		n           = group_start ? '0 : count;
		count_next  = n;
		held_next   = held;
		face_first  = '0;
		face_second = '0;
		face_num    = 2'd0;
		append      = 1'b0;

		unique case (mode_e'(mode))
			MODE_TRIS: begin
				if (n >= COUNT_BITS'(2)) begin
					face_first = make_face(held[0], held[1], vertex_id, 1'b1);
					face_num   = 2'd1;
					count_next = '0;
				end else begin
					append = 1'b1;
				end
			end
			MODE_STRIP: begin
				if (n >= COUNT_BITS'(2)) begin
					face_first   = make_face(held[0], held[1], vertex_id, 1'b1);
					face_num     = 2'd1;
					held_next[0] = held[1];
					held_next[1] = vertex_id;
					count_next   = COUNT_BITS'(2);
				end else begin
					append = 1'b1;
				end
			end
			MODE_FAN: begin
				if (n >= COUNT_BITS'(2)) begin
					face_first   = make_face(held[0], held[1], vertex_id, 1'b1);
					face_num     = 2'd1;
					held_next[1] = vertex_id;
					count_next   = COUNT_BITS'(2);
				end else begin
					append = 1'b1;
				end
			end
			MODE_QUADS: begin
				if (n == COUNT_BITS'(3)) begin
					// quad split: (v0,v1,v3),(v3,v1,v2)
					face_first  = make_face(held[0], held[1], vertex_id, 1'b0);
					face_second = make_face(vertex_id, held[1], held[2], 1'b1);
					face_num    = 2'd2;
					count_next  = '0;
				end else begin
					append = 1'b1;
				end
			end
			MODE_QSTRIP: begin
				if (n == COUNT_BITS'(3)) begin
					face_first   = make_face(held[0], held[1], held[2], 1'b0);
					face_second  = make_face(held[2], held[1], vertex_id, 1'b1);
					face_num     = 2'd2;
					held_next[0] = held[2];
					held_next[1] = vertex_id;
					count_next   = COUNT_BITS'(2);
				end else begin
					append = 1'b1;
				end
			end
			default: begin
				// unknown mode: vertex dropped, only the group clear applies
			end
		endcase

		if (append) begin
			// append only happens with n below 3
			unique case (n)
				COUNT_BITS'(0): held_next[0] = vertex_id;
				COUNT_BITS'(1): held_next[1] = vertex_id;
				default:        held_next[2] = vertex_id;
			endcase
			count_next = n + COUNT_BITS'(1);
		end
	end

endmodule

[rtl/pia_out_buf.sv]
module pia_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pia_pkg::face_t face_first,
	input  pia_pkg::face_t face_second,
	input  logic [1:0]     face_num,
	output logic           room,
	output logic           out_valid,
	input  logic           out_stall,
	output pia_pkg::face_t face_out
);
	import pia_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_BITS = $clog2(DEPTH);

	face_t               mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [PTR_BITS:0]   count_q;
	logic [1:0]          push_num;
	logic                pop;

	assign push_num  = push ? face_num : 2'd0;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign face_out  = mem_q[rd_ptr_q];
	// space for the two faces a single vertex may produce
	assign room      = (count_q <= (PTR_BITS+1)'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_BITS'(push_num);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			count_q <= count_q + (PTR_BITS+1)'(push_num) - (PTR_BITS+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_num != 2'd0)
			mem_q[wr_ptr_q] <= face_first;
		if (push_num == 2'd2)
			mem_q[wr_ptr_q + PTR_BITS'(1)] <= face_second;
	end

endmodule

[rtl/primitive_index_assembly.sv]
// A face is registered into the four-entry output queue on its vertex transfer.
// Throughput: one vertex per cycle while not stalled; a vertex closing a quad yields
// two faces, which leave the queue one per cycle while out_stall is low.
// Input stall rises while fewer than two queue entries are free.
// Reset (arst_n low, asynchronous): mode back to separate triangles, held count
// and output queue emptied; held indices keep no defined value.
module primitive_index_assembly #(
	parameter int INDEX_BITS = pia_pkg::INDEX_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pia_pkg::MODE_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pia_pkg::FIELD_BITS-1:0]    vertex_index,
	input  logic                              group_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pia_pkg::FIELD_BITS-1:0]    corner_a,
	output logic [pia_pkg::FIELD_BITS-1:0]    corner_b,
	output logic [pia_pkg::FIELD_BITS-1:0]    corner_c,
	output logic                              last_of_run
);
	import pia_pkg::*;

	localparam int HELD_BITS = (INDEX_BITS < FIELD_BITS) ? INDEX_BITS : FIELD_BITS;

	logic [MODE_BITS-1:0]                        mode_q;
	logic [COUNT_BITS-1:0]                       count_q;
	logic [HELD_DEPTH-1:0][HELD_BITS-1:0]        held_q;
	logic [COUNT_BITS-1:0]                       count_next;
	logic [HELD_DEPTH-1:0][HELD_BITS-1:0]        held_next;
	face_t                                       face_first;
	face_t                                       face_second;
	face_t                                       face_out;
	logic [1:0]                                  face_num;
	logic                                        room;
	logic                                        accept;

	assign in_stall = !room;
	assign accept   = in_valid && room;

	pia_assemble #(
		.HELD_BITS(HELD_BITS)
	) u_assemble (
		.mode        (mode_q),
		.group_start (group_start),
		.vertex_id   (vertex_index[HELD_BITS-1:0]),
		.count       (count_q),
		.held        (held_q),
		.count_next  (count_next),
		.held_next   (held_next),
		.face_first  (face_first),
		.face_second (face_second),
		.face_num    (face_num)
	);

	pia_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (accept),
		.face_first  (face_first),
		.face_second (face_second),
		.face_num    (face_num),
		.room        (room),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.face_out    (face_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_TRIS;
			count_q <= '0;
		end else begin
			if (cfg_write)
				mode_q <= cfg_data;
			if (accept)
				count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_next;
	end

	assign corner_a    = face_out.a;
	assign corner_b    = face_out.b;
	assign corner_c    = face_out.c;
	assign last_of_run = face_out.last;

endmodule

[rtl/pia_checker.sv]
module pia_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [pia_pkg::FIELD_BITS-1:0]    corner_a,
	input logic [pia_pkg::FIELD_BITS-1:0]    corner_b,
	input logic [pia_pkg::FIELD_BITS-1:0]    corner_c,
	input logic                              last_of_run
);

	// stalled face holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(corner_a) && $stable(corner_b)
			&& $stable(corner_c) && $stable(last_of_run))
		else $error("output face changed while stalled");

	// input is only held off while faces are queued
	a_stall_needs_data: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output queue");

	// first face of a pair is followed directly by its partner
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("second face of a pair missing");

	// no face appears without a vertex transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && !in_stall) |=> !out_valid)
		else $error("face appeared without a vertex transfer");

endmodule

bind primitive_index_assembly pia_checker u_pia_checker (.*);
